// ===== src/cnia_pkg.sv =====
// Package: byte positions, address type and byte-level helpers for the neutral address former.
`default_nettype none
package cnia_pkg;

	localparam int unsigned FILL_OFFSET        = 8;
	localparam int unsigned FILL_BYTES         = 8;
	localparam int unsigned ADJUST_WITHIN_FILL = 3;

	localparam int unsigned FILL_COUNT = (FILL_BYTES < 8) ? FILL_BYTES : 8;
	localparam int unsigned ADJ_HI     = (FILL_OFFSET + ADJUST_WITHIN_FILL) % 16;
	localparam int unsigned ADJ_LO     = (ADJ_HI + 1) % 16;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned PART_W  = 18;
	localparam int unsigned GROUPS  = 4;
	localparam int unsigned ACC_W   = 21;
	localparam int unsigned FOLD_W  = 17;

	// Byte 0 of the address sits in the most significant byte.
	typedef logic [0:15][7:0] addr_t;

	typedef logic [0:7][7:0] fill_t;

	typedef logic [PART_W-1:0] part_t;

	function automatic addr_t fill_address(addr_t src, fill_t fill);
		addr_t a;
		a = src;
		for (int unsigned k = 0; k < FILL_COUNT; k++) begin
			a[(FILL_OFFSET + k) % 16] = fill[k];
		end
		return a;
	endfunction

	function automatic logic [WORD_W-1:0] le_word(addr_t a, int unsigned i);
		return {a[2*i+1], a[2*i]};
	endfunction

endpackage
`default_nettype wire

// ===== src/checksum_neutral_ipv6_address_top.sv =====
// Top level: three-stage pipeline forming a checksum-neutral IPv6 address.
//
// One request beat per clock: start with busy low is accepted every cycle and busy
// never rises. Each result appears on neutral_high/neutral_low with done high for
// exactly one cycle, behind the s1, s2 and done registers; the receiver cannot stall it.
// The stages are the fill and partial word sums, the final sum with the first fold,
// and the last fold with the adjustment and write-back of the checksum word.
`default_nettype none
module checksum_neutral_ipv6_address_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] ipv4_address,
	input  wire logic [63:0] prefix_high,
	input  wire logic [63:0] prefix_low,
	input  wire logic [63:0] source_high,
	input  wire logic [63:0] source_low,
	input  wire logic [63:0] random_fill,
	output logic             done,
	output logic [63:0]      neutral_high,
	output logic [63:0]      neutral_low
);

	localparam int unsigned WW = cnia_pkg::WORD_W;

	logic                          valid_s1;
	cnia_pkg::addr_t               addr_s1;
	logic [WW-1:0]                 mid_s1;
	logic [WW:0]                   s4_s1;
	cnia_pkg::part_t [cnia_pkg::GROUPS-1:0] part_s1;

	logic                          valid_s2;
	cnia_pkg::addr_t               addr_s2;
	logic [cnia_pkg::FOLD_W-1:0]   a_s2;
	logic [cnia_pkg::FOLD_W-1:0]   b_s2;

	cnia_pkg::addr_t               addr_c1;
	cnia_pkg::addr_t               pfx_c1;
	cnia_pkg::part_t [cnia_pkg::GROUPS-1:0] part_c1;
	logic [WW-1:0]                 v4w0_c1;
	logic [WW-1:0]                 v4w1_c1;

	logic [cnia_pkg::ACC_W-1:0]    acc_c2;
	logic [WW:0]                   s4f_c2;

	logic [WW-1:0]                 a_c3;
	logic [WW-1:0]                 b_c3;
	logic [WW-1:0]                 nw_c3;
	cnia_pkg::addr_t               addr_c3;

	assign busy = 1'b0;

	always_comb begin
		addr_c1 = cnia_pkg::fill_address(cnia_pkg::addr_t'({source_high, source_low}),
			cnia_pkg::fill_t'(random_fill));
		pfx_c1  = cnia_pkg::addr_t'({prefix_high, prefix_low});
		v4w0_c1 = {ipv4_address[23:16], ipv4_address[31:24]};
		v4w1_c1 = {ipv4_address[7:0], ipv4_address[15:8]};
		for (int unsigned g = 0; g < cnia_pkg::GROUPS; g++) begin
			part_c1[g] = '0;
			for (int unsigned w = 0; w < 2; w++) begin
				part_c1[g] = part_c1[g]
					+ cnia_pkg::PART_W'(cnia_pkg::le_word(pfx_c1, 2*g + w))
					+ cnia_pkg::PART_W'(cnia_pkg::le_word(addr_c1, 2*g + w));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_c1;
		mid_s1  <= {addr_c1[cnia_pkg::ADJ_HI], addr_c1[cnia_pkg::ADJ_LO]};
		s4_s1   <= (WW+1)'(v4w0_c1) + (WW+1)'(v4w1_c1);
		part_s1 <= part_c1;
	end

	always_comb begin
		acc_c2 = {{(cnia_pkg::ACC_W-WW){1'b0}}, ~mid_s1};
		for (int unsigned g = 0; g < cnia_pkg::GROUPS; g++) begin
			acc_c2 = acc_c2 + cnia_pkg::ACC_W'(part_s1[g]);
		end
		s4f_c2 = (WW+1)'(s4_s1[WW-1:0]) + (WW+1)'(s4_s1[WW]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= addr_s1;
		a_s2    <= cnia_pkg::FOLD_W'(acc_c2[WW-1:0])
			+ cnia_pkg::FOLD_W'(acc_c2[cnia_pkg::ACC_W-1:WW]);
		b_s2    <= s4f_c2;
	end

	always_comb begin
		a_c3 = a_s2[WW-1:0] + WW'(a_s2[cnia_pkg::FOLD_W-1:WW]);
		b_c3 = b_s2[WW-1:0] + WW'(b_s2[cnia_pkg::FOLD_W-1:WW]);
		if (a_c3 > b_c3) begin
			nw_c3 = ~(a_c3 - b_c3);
		end else begin
			nw_c3 = ~(a_c3 - b_c3 - WW'(1));
		end
		addr_c3 = addr_s2;
		addr_c3[cnia_pkg::ADJ_HI] = nw_c3[WW-1:8];
		addr_c3[cnia_pkg::ADJ_LO] = nw_c3[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		{neutral_high, neutral_low} <= addr_c3;
	end

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (valid_s1 == $past(start)))
		else $error("accepted beat did not enter stage one");

	a_s2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (valid_s2 == $past(valid_s1)))
		else $error("stage two valid lost or invented");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (done == $past(valid_s2)))
		else $error("result strobe lost or invented");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule
`default_nettype wire
